FILE: hw/rtl/wvh_pkg.sv
// shared types and constants for the wav header validator
// no dependencies; imported by wav_header_validator_top
`default_nettype none

package wvh_pkg;

  localparam int BYTE_W      = 8;
  localparam int HALF_W      = 16;
  localparam int WORD_W      = 32;
  localparam int POS_W       = WORD_W + 1;        // byte count saturates at 2^32
  localparam int PROD_W      = WORD_W + HALF_W;   // clip seconds times byte rate
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_FIELD_W = STATUS_W + HALF_W + WORD_W + HALF_W + WORD_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + BYTE_W - 1) / BYTE_W) * BYTE_W;

  // tags as they sit in the byte stream, first byte in the low bits
  localparam logic [WORD_W-1:0] RIFF_TAG = 32'h4646_4952;
  localparam logic [WORD_W-1:0] WAVE_TAG = 32'h4556_4157;
  // chunk tags as they sit after shifting in first byte first
  localparam logic [WORD_W-1:0] FMT_TAG  = 32'h666D_7420;
  localparam logic [WORD_W-1:0] DATA_TAG = 32'h6461_7461;

  localparam logic [WORD_W-1:0] HDR_START      = 32'd12;
  localparam logic [WORD_W-1:0] HDR_LEN        = 32'd8;
  localparam logic [WORD_W-1:0] SIZE_FIELD_OFS = 32'd4;
  localparam logic [BYTE_W-1:0] PCM_TAG_LOW    = 8'h01;
  localparam logic [HALF_W-1:0] BITS_8         = 16'd8;
  localparam logic [HALF_W-1:0] BITS_16        = 16'd16;

  localparam logic [WORD_W-1:0] RST_FILE_SIZE     = 32'd0;
  localparam logic [HALF_W-1:0] RST_MAX_CHANNELS  = 16'd2;
  localparam logic [WORD_W-1:0] RST_REQUIRED_RATE = 32'd44100;
  localparam logic [HALF_W-1:0] RST_MAX_CLIP_SEC  = 16'd10;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_NOT_WAVE = 3'd1,
    STS_CHUNK    = 3'd2,
    STS_NOT_PCM  = 3'd3,
    STS_CHANNELS = 3'd4,
    STS_RATE     = 3'd5,
    STS_BITS     = 3'd6,
    STS_LENGTH   = 3'd7
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILE_SIZE     = 2'd0,
    CFG_MAX_CHANNELS  = 2'd1,
    CFG_REQUIRED_RATE = 2'd2,
    CFG_MAX_CLIP_SEC  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [HALF_W-1:0] channel_count;
    logic [WORD_W-1:0] rate_found;
    logic [HALF_W-1:0] sample_bits;
    logic [WORD_W-1:0] payload_length;
  } fields_t;

  // snapshot of the file state taken on the flagged byte
  typedef struct packed {
    status_t           err;
    logic              long_enough;
    logic              pcm;
    logic [WORD_W-1:0] byte_rate;
    fields_t           f;
  } fin_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wav_header_validator_top.sv
// wav header validator: checks a riff/wave file streamed one byte per transfer
// depends on wvh_pkg
//
// usage
//   in_*  : one file byte per transfer, in_tlast on the final byte of the file
//   out_* : one result per file, sent after the flagged byte; status is zero
//           for a good file, else the lowest code among the checks that fail,
//           together with the format fields and data chunk length held
//   cfg_* : register writes; the user makes them only while no file is in flight, unenforced
// throughput: one byte per cycle while the result stages have room; files may follow back to back
// result path: out_tvalid follows the flagged byte through the snapshot,
//   status and multiply, and final compare registers; the clip-length
//   product is the one registered multiply on that path
// stalls: a held result blocks only once all three result stages are full;
//   byte transfers that end no file keep flowing otherwise
// reset: rst_n low clears all file state, empties the result stages and
//   loads the register defaults; after each file the file state clears itself
`default_nettype none

module wav_header_validator_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [wvh_pkg::BYTE_W-1:0]       in_tdata,   // data_byte
  input  wire logic                             in_tlast,   // last_byte
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status, channel_count, rate_found, sample_bits, payload_length, zero pad
  output logic [wvh_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [wvh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wvh_pkg::WORD_W-1:0]       cfg_data
);
  import wvh_pkg::*;

  // configuration
  logic [WORD_W-1:0] file_size_r;
  logic [HALF_W-1:0] max_channels_r;
  logic [WORD_W-1:0] required_rate_r;
  logic [HALF_W-1:0] max_clip_r;

  // file state
  logic [POS_W-1:0]  pos_r,      pos_nxt;
  logic [WORD_W-1:0] hdr_pos_r,  hdr_pos_nxt;
  logic [WORD_W-1:0] tag_r,      tag_nxt;
  logic [WORD_W-1:0] size_r,     size_nxt;
  logic [WORD_W-1:0] fbase_r,    fbase_nxt;
  logic              fvalid_r,   fvalid_nxt;
  logic [BYTE_W-1:0] ftag_low_r, ftag_low_nxt;
  logic              pcm_r,      pcm_nxt;
  logic [HALF_W-1:0] chan_r,     chan_nxt;
  logic [WORD_W-1:0] rate_r,     rate_nxt;
  logic [WORD_W-1:0] brate_r,    brate_nxt;
  logic [HALF_W-1:0] bits_r,     bits_nxt;
  logic [WORD_W-1:0] dlen_r,     dlen_nxt;
  status_t           err_r,      err_nxt;
  logic              walking_r,  walking_nxt;

  // result stages
  logic              s1_valid_r;
  fin_t              s1_r,       s1_nxt;
  logic              s2_valid_r;
  status_t           s2_sts_r,   s2_sts_nxt;
  logic              s2_clip_r,  s2_clip_nxt;
  logic              s2_bzero_r;
  logic [PROD_W-1:0] s2_prod_r;
  fields_t           s2_f_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic in_xfer, out_move, s2_move, s1_move;

  logic [WORD_W-1:0] p32;
  logic [BYTE_W-1:0] fbyte;
  logic [WORD_W-1:0] fmt_off;
  logic [WORD_W-1:0] hdr_off;
  logic [WORD_W-1:0] size_full;
  logic [POS_W-1:0]  hdr_end;
  logic [POS_W-1:0]  next_hdr;
  logic [WORD_W-1:0] size_room;
  status_t           fin_sts;
  logic              clip_long;

  assign out_move  = !out_valid_r || out_tready;
  assign s2_move   = !s2_valid_r || out_move;
  assign s1_move   = !s1_valid_r || s2_move;
  assign in_tready = s1_move;
  assign in_xfer   = in_tvalid && in_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r     <= RST_FILE_SIZE;
      max_channels_r  <= RST_MAX_CHANNELS;
      required_rate_r <= RST_REQUIRED_RATE;
      max_clip_r      <= RST_MAX_CLIP_SEC;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FILE_SIZE:     file_size_r     <= cfg_data;
        CFG_MAX_CHANNELS:  max_channels_r  <= cfg_data[HALF_W-1:0];
        CFG_REQUIRED_RATE: required_rate_r <= cfg_data;
        CFG_MAX_CLIP_SEC:  max_clip_r      <= cfg_data[HALF_W-1:0];
      endcase
    end
  end

  assign p32       = pos_r[WORD_W-1:0];
  assign fbyte     = (p32 >= file_size_r) ? '0 : in_tdata;
  assign fmt_off   = p32 - fbase_r;
  assign hdr_off   = p32 - hdr_pos_r;
  assign hdr_end   = {1'b0, hdr_pos_r} + {1'b0, HDR_LEN};
  assign size_room = file_size_r - hdr_pos_r - SIZE_FIELD_OFS;

  always_comb begin
    size_full = size_r;
    unique case (hdr_off[1:0])
      2'd0: size_full[7:0]   = in_tdata;
      2'd1: size_full[15:8]  = in_tdata;
      2'd2: size_full[23:16] = in_tdata;
      2'd3: size_full[31:24] = in_tdata;
    endcase
  end

  assign next_hdr = {1'b0, hdr_pos_r} + {1'b0, size_full} + {1'b0, HDR_LEN};

  // per-byte state update
  always_comb begin
    pos_nxt      = pos_r;
    hdr_pos_nxt  = hdr_pos_r;
    tag_nxt      = tag_r;
    size_nxt     = size_r;
    fbase_nxt    = fbase_r;
    fvalid_nxt   = fvalid_r;
    ftag_low_nxt = ftag_low_r;
    pcm_nxt      = pcm_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    brate_nxt    = brate_r;
    bits_nxt     = bits_r;
    dlen_nxt     = dlen_r;
    err_nxt      = err_r;
    walking_nxt  = walking_r;

    if (in_xfer && !pos_r[WORD_W]) begin
      // riff and wave signatures
      if (err_nxt == STS_OK && p32 < 32'd4 &&
          in_tdata != RIFF_TAG[8*p32[1:0] +: BYTE_W]) begin
        err_nxt = STS_NOT_WAVE;
      end
      if (err_nxt == STS_OK && p32 >= 32'd8 && p32 < 32'd12 &&
          in_tdata != WAVE_TAG[8*p32[1:0] +: BYTE_W]) begin
        err_nxt = STS_NOT_WAVE;
      end

      // fmt field capture, offsets from the fmt chunk header
      if (fvalid_r && err_nxt == STS_OK && p32 >= fbase_r && fmt_off[WORD_W-1:5] == '0) begin
        case (fmt_off[4:0])
          5'd8:  ftag_low_nxt = fbyte;
          5'd9:  if (ftag_low_r == PCM_TAG_LOW && fbyte == '0) pcm_nxt = 1'b1;
          5'd10: chan_nxt[7:0]   = fbyte;
          5'd11: chan_nxt[15:8]  = fbyte;
          5'd12: rate_nxt[7:0]   = fbyte;
          5'd13: rate_nxt[15:8]  = fbyte;
          5'd14: rate_nxt[23:16] = fbyte;
          5'd15: rate_nxt[31:24] = fbyte;
          5'd16: brate_nxt[7:0]   = fbyte;
          5'd17: brate_nxt[15:8]  = fbyte;
          5'd18: brate_nxt[23:16] = fbyte;
          5'd19: brate_nxt[31:24] = fbyte;
          5'd22: bits_nxt[7:0]  = fbyte;
          5'd23: bits_nxt[15:8] = fbyte;
          default: ;
        endcase
      end

      // chunk header walk
      if (walking_r && err_nxt == STS_OK && p32 >= hdr_pos_r && hdr_off < HDR_LEN) begin
        if (!hdr_off[2]) begin
          tag_nxt = {tag_r[WORD_W-BYTE_W-1:0], in_tdata};
        end else if (hdr_off[1:0] != 2'd3) begin
          size_nxt = size_full;
        end else begin
          if (hdr_end >= {1'b0, file_size_r}) begin
            walking_nxt = 1'b0;
          end else if (size_full > size_room) begin
            err_nxt     = STS_CHUNK;
            walking_nxt = 1'b0;
          end else begin
            if (tag_r == FMT_TAG) begin
              fvalid_nxt   = 1'b1;
              fbase_nxt    = hdr_pos_r;
              chan_nxt     = '0;
              rate_nxt     = '0;
              brate_nxt    = '0;
              bits_nxt     = '0;
              ftag_low_nxt = '0;
            end else if (tag_r == DATA_TAG) begin
              dlen_nxt = size_full;
            end
            if (next_hdr[WORD_W]) walking_nxt = 1'b0;
            else                  hdr_pos_nxt = next_hdr[WORD_W-1:0];
          end
          tag_nxt  = '0;
          size_nxt = '0;
        end
      end

      // file ends right after the format tag low byte: high byte reads as zero
      if (in_tlast && fvalid_nxt && err_nxt == STS_OK && p32 >= fbase_nxt &&
          (p32 - fbase_nxt) == HDR_LEN && ftag_low_nxt == PCM_TAG_LOW) begin
        pcm_nxt = 1'b1;
      end

      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_comb begin
    s1_nxt.err              = err_nxt;
    s1_nxt.long_enough      = pos_nxt >= POS_W'(HDR_START);
    s1_nxt.pcm              = pcm_nxt;
    s1_nxt.byte_rate        = brate_nxt;
    s1_nxt.f.channel_count  = chan_nxt;
    s1_nxt.f.rate_found     = rate_nxt;
    s1_nxt.f.sample_bits    = bits_nxt;
    s1_nxt.f.payload_length = dlen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_xfer && in_tlast)) begin
      pos_r      <= '0;
      hdr_pos_r  <= HDR_START;
      tag_r      <= '0;
      size_r     <= '0;
      fbase_r    <= '0;
      fvalid_r   <= 1'b0;
      ftag_low_r <= '0;
      pcm_r      <= 1'b0;
      chan_r     <= '0;
      rate_r     <= '0;
      brate_r    <= '0;
      bits_r     <= '0;
      dlen_r     <= '0;
      err_r      <= STS_OK;
      walking_r  <= 1'b1;
    end else begin
      pos_r      <= pos_nxt;
      hdr_pos_r  <= hdr_pos_nxt;
      tag_r      <= tag_nxt;
      size_r     <= size_nxt;
      fbase_r    <= fbase_nxt;
      fvalid_r   <= fvalid_nxt;
      ftag_low_r <= ftag_low_nxt;
      pcm_r      <= pcm_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      brate_r    <= brate_nxt;
      bits_r     <= bits_nxt;
      dlen_r     <= dlen_nxt;
      err_r      <= err_nxt;
      walking_r  <= walking_nxt;
    end
  end

  // stage 1: snapshot of the finished file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_move) begin
      s1_valid_r <= in_xfer && in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && in_xfer && in_tlast) s1_r <= s1_nxt;
  end

  // stage 2: ordered checks except clip length, and the clip product
  always_comb begin
    s2_clip_nxt = 1'b0;
    if (s1_r.err != STS_OK)                        s2_sts_nxt = s1_r.err;
    else if (!s1_r.long_enough)                    s2_sts_nxt = STS_NOT_WAVE;
    else if (!s1_r.pcm)                            s2_sts_nxt = STS_NOT_PCM;
    else if (s1_r.f.channel_count == '0 ||
             s1_r.f.channel_count > max_channels_r) s2_sts_nxt = STS_CHANNELS;
    else if (s1_r.f.rate_found != required_rate_r) s2_sts_nxt = STS_RATE;
    else if (s1_r.f.sample_bits != BITS_16 &&
             s1_r.f.sample_bits != BITS_8)         s2_sts_nxt = STS_BITS;
    else if (s1_r.f.payload_length == '0)          s2_sts_nxt = STS_LENGTH;
    else begin
      s2_sts_nxt  = STS_OK;
      s2_clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_move) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s1_valid_r) begin
      s2_sts_r   <= s2_sts_nxt;
      s2_clip_r  <= s2_clip_nxt;
      s2_bzero_r <= s1_r.byte_rate == '0;
      s2_prod_r  <= PROD_W'(max_clip_r) * PROD_W'(s1_r.byte_rate);
      s2_f_r     <= s1_r.f;
    end
  end

  // output stage: clip length compare and result register
  assign clip_long = s2_bzero_r || (PROD_W'(s2_f_r.payload_length) > s2_prod_r);
  assign fin_sts   = (s2_clip_r && clip_long) ? STS_LENGTH : s2_sts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && s2_valid_r) begin
      out_data_r <= OUT_TDATA_W'({s2_f_r.payload_length, s2_f_r.sample_bits,
                                  s2_f_r.rate_found, s2_f_r.channel_count, fin_sts});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // input stalls only when every result stage holds a file
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s2_valid_r && out_valid_r))
    else $error("input stalled with a free result stage");

  // a flagged byte always leaves a snapshot and clears the file state
  a_last_snap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> (s1_valid_r && pos_r == '0 && err_r == STS_OK))
    else $error("flagged byte did not close the file");

  // the clip test only runs when every earlier check passed
  a_clip_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_clip_r) |-> (s2_sts_r == STS_OK))
    else $error("clip test armed behind an earlier error");

  // a chunk size error stops the header walk
  a_err_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r == STS_CHUNK) |-> !walking_r)
    else $error("header walk continued after a chunk size error");

endmodule

`default_nettype wire

FILE: tb/sv/wav_header_validator_top_test.sv
// self-checking bench for wav_header_validator_top: streams riff/wave files a byte per
// transfer, predicts each file verdict in a local model and compares every result field
// depends on wvh_pkg and wav_header_validator_top
module wav_header_validator_top_test;
  import wvh_pkg::*;

  localparam int CH_LSB   = STATUS_W;
  localparam int RATE_LSB = CH_LSB + HALF_W;
  localparam int BITS_LSB = RATE_LSB + WORD_W;
  localparam int LEN_LSB  = BITS_LSB + HALF_W;

  typedef logic [63:0] u64_t;
  typedef struct {
    status_t st;
    fields_t f;
  } verdict_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata;    // data_byte
  logic                   in_tlast;    // last_byte
  logic                   out_tvalid;
  logic                   out_tready;
  // status, channel_count, rate_found, sample_bits, payload_length, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [WORD_W-1:0]      cfg_data;

  wav_header_validator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies
  logic [WORD_W-1:0] fs_r;
  logic [HALF_W-1:0] maxch_r;
  logic [WORD_W-1:0] rate_r;
  logic [HALF_W-1:0] clip_r;

  // parser state of the file in flight
  logic [POS_W-1:0]  byte_pos;
  logic [WORD_W-1:0] hdr_pos;
  logic [WORD_W-1:0] tag_sr;
  logic [WORD_W-1:0] size_sr;
  logic [WORD_W-1:0] fmt_base;
  logic              fmt_seen;
  logic [BYTE_W-1:0] tag_lo;
  logic              pcm_ok;
  logic [HALF_W-1:0] ch_h;
  logic [WORD_W-1:0] rate_h;
  logic [WORD_W-1:0] brate_h;
  logic [HALF_W-1:0] bits_h;
  logic [WORD_W-1:0] dlen_h;
  status_t           err_h;
  logic              walk_on;

  verdict_t          verdict_q[$];
  logic [BYTE_W-1:0] file_bytes[$];
  logic              steady;
  int                mismatches = 0;
  int                files_checked = 0;
  int                bytes_sent = 0;
  int                status_seen[8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d verdicts pending", verdict_q.size());
    $display("** wav_header_validator_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  task automatic clear_file();
    byte_pos = '0;
    hdr_pos  = HDR_START;
    tag_sr   = '0;
    size_sr  = '0;
    fmt_base = '0;
    fmt_seen = 1'b0;
    tag_lo   = '0;
    pcm_ok   = 1'b0;
    ch_h     = '0;
    rate_h   = '0;
    brate_h  = '0;
    bits_h   = '0;
    dlen_h   = '0;
    err_h    = STS_OK;
    walk_on  = 1'b1;
  endtask

  task automatic grab_fmt_byte(input u64_t p, input logic [BYTE_W-1:0] b);
    u64_t off;
    logic [BYTE_W-1:0] v;
    if (!fmt_seen || err_h != STS_OK || p < fmt_base) return;
    off = p - fmt_base;
    // fmt bytes past the declared file end read as zero
    v = (p >= fs_r) ? 8'h00 : b;
    case (off)
      8: tag_lo = v;
      9: if (tag_lo == PCM_TAG_LOW && v == 8'h00) pcm_ok = 1'b1;
      10: ch_h[7:0] = v;
      11: ch_h[15:8] = v;
      12, 13, 14, 15: rate_h = rate_h | (32'(v) << (8 * (off - 12)));
      16, 17, 18, 19: brate_h = brate_h | (32'(v) << (8 * (off - 16)));
      22: bits_h[7:0] = v;
      23: bits_h[15:8] = v;
      default: ;
    endcase
  endtask

  task automatic walk_byte(input u64_t p, input logic [BYTE_W-1:0] b);
    u64_t h;
    u64_t off;
    u64_t nxt;
    h = u64_t'(hdr_pos);
    if (!walk_on || err_h != STS_OK || p < h || p - h >= 8) return;
    off = p - h;
    if (off < 4) begin
      tag_sr = {tag_sr[23:0], b};
      return;
    end
    size_sr = size_sr | (32'(b) << (8 * (off - 4)));
    if (off != 7) return;
    if (h + 8 >= u64_t'(fs_r)) begin
      walk_on = 1'b0;
    end else if (u64_t'(size_sr) > u64_t'(fs_r) - h - 4) begin
      err_h = STS_CHUNK;
      walk_on = 1'b0;
    end else begin
      if (tag_sr == FMT_TAG) begin
        fmt_seen = 1'b1;
        fmt_base = h[31:0];
        ch_h = '0;
        rate_h = '0;
        brate_h = '0;
        bits_h = '0;
        tag_lo = '0;
      end else if (tag_sr == DATA_TAG) begin
        dlen_h = size_sr;
      end
      nxt = h + u64_t'(size_sr) + 8;
      if (nxt[63:32] != 0) walk_on = 1'b0;
      else hdr_pos = nxt[31:0];
    end
    tag_sr = '0;
    size_sr = '0;
  endtask

  function automatic status_t file_verdict();
    if (err_h != STS_OK) return err_h;
    if (byte_pos < 12) return STS_NOT_WAVE;
    if (!pcm_ok) return STS_NOT_PCM;
    if (ch_h == 0 || ch_h > maxch_r) return STS_CHANNELS;
    if (rate_h != rate_r) return STS_RATE;
    if (bits_h != BITS_16 && bits_h != BITS_8) return STS_BITS;
    if (dlen_h == 0) return STS_LENGTH;
    if (brate_h == 0 || u64_t'(dlen_h) > u64_t'(clip_r) * u64_t'(brate_h))
      return STS_LENGTH;
    return STS_OK;
  endfunction

  task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic lst);
    u64_t p;
    verdict_t vr;
    p = u64_t'(byte_pos);
    if (!byte_pos[WORD_W]) begin
      if (err_h == STS_OK && p < 4 && b != RIFF_TAG[8 * p[1:0] +: 8]) err_h = STS_NOT_WAVE;
      if (err_h == STS_OK && p >= 8 && p < 12 && b != WAVE_TAG[8 * p[1:0] +: 8])
        err_h = STS_NOT_WAVE;
      grab_fmt_byte(p, b);
      walk_byte(p, b);
      // file ends right after the format tag low byte: high byte reads as zero
      if (lst && fmt_seen && err_h == STS_OK && p >= fmt_base && p - fmt_base == 8 &&
          tag_lo == PCM_TAG_LOW)
        pcm_ok = 1'b1;
      byte_pos = byte_pos + 1'b1;
    end
    if (lst) begin
      vr.st = file_verdict();
      vr.f.channel_count = ch_h;
      vr.f.rate_found = rate_h;
      vr.f.sample_bits = bits_h;
      vr.f.payload_length = dlen_h;
      verdict_q.push_back(vr);
      clear_file();
    end
  endtask

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    verdict_t vr;
    if (verdict_q.size() == 0) begin
      $display("%0t unexpected result, no file pending: expected none actual %h",
               $time, out_tdata);
      mismatches++;
      return;
    end
    vr = verdict_q.pop_front();
    check_field("status", 32'(vr.st), 32'(out_tdata[STATUS_W-1:0]));
    check_field("channel_count", 32'(vr.f.channel_count), 32'(out_tdata[CH_LSB +: HALF_W]));
    check_field("rate_found", vr.f.rate_found, out_tdata[RATE_LSB +: WORD_W]);
    check_field("sample_bits", 32'(vr.f.sample_bits), 32'(out_tdata[BITS_LSB +: HALF_W]));
    check_field("payload_length", vr.f.payload_length, out_tdata[LEN_LSB +: WORD_W]);
    check_field("pad", '0, 32'(out_tdata[OUT_TDATA_W-1:OUT_FIELD_W]));
    files_checked++;
    status_seen[int'(vr.st)]++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fs_r    = RST_FILE_SIZE;
      maxch_r = RST_MAX_CHANNELS;
      rate_r  = RST_REQUIRED_RATE;
      clip_r  = RST_MAX_CLIP_SEC;
      clear_file();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_FILE_SIZE:     fs_r = cfg_data;
          CFG_MAX_CHANNELS:  maxch_r = cfg_data[HALF_W-1:0];
          CFG_REQUIRED_RATE: rate_r = cfg_data;
          CFG_MAX_CLIP_SEC:  clip_r = cfg_data[HALF_W-1:0];
          default: ;
        endcase
      end
      // a result never belongs to the byte of the same edge, so check first
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tlast);
        bytes_sent++;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // result side: bursts of ready, mostly short stalls, now and then a long one
  initial begin
    int n;
    int m;
    int r;
    out_tready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      n = (r < 75) ? $urandom_range(1, 4) : $urandom_range(10, 60);
      repeat (n) @(negedge clk) out_tready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 20) m = 0;
      else if (r < 75) m = $urandom_range(1, 3);
      else if (r < 95) m = $urandom_range(4, 10);
      else m = $urandom_range(20, 40);
      repeat (m) @(negedge clk) out_tready <= 1'b0;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lst);
    int gap;
    gap = steady ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= lst;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  task automatic send_file();
    steady = ($urandom_range(0, 3) == 0);
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // sender stops until every pending verdict has been checked
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_regs(input logic [WORD_W-1:0] fs, input logic [HALF_W-1:0] mc,
                           input logic [WORD_W-1:0] rt, input logic [HALF_W-1:0] clip);
    drain_results();
    write_reg(CFG_FILE_SIZE, fs);
    write_reg(CFG_MAX_CHANNELS, 32'(mc));
    write_reg(CFG_REQUIRED_RATE, rt);
    write_reg(CFG_MAX_CLIP_SEC, 32'(clip));
  endtask

  // ---------------------------------------------------------------- file builders

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endtask

  task automatic put_le(input logic [WORD_W-1:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8 * i +: 8]);
  endtask

  task automatic put_rand(input int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  task automatic begin_wave();
    file_bytes.delete();
    put_text("RIFF");
    put_le($urandom, 4);
    put_text("WAVE");
  endtask

  // fmt chunk; a declared length under 16 lets the next header overlap the fields
  task automatic put_fmt(input logic [15:0] ftag, input logic [15:0] ch,
                         input logic [31:0] rt, input logic [31:0] br,
                         input logic [15:0] bits, input int flen);
    logic [127:0] body;
    body = {bits, 16'($urandom), br, rt, ch, ftag};
    put_text("fmt ");
    put_le(flen, 4);
    for (int i = 0; i < flen && i < 16; i++) file_bytes.push_back(body[8 * i +: 8]);
    if (flen > 16) put_rand(flen - 16);
  endtask

  task automatic put_data(input logic [31:0] dlen, input int payload);
    put_text("data");
    put_le(dlen, 4);
    put_rand(payload);
  endtask

  task automatic wave_file(input logic [15:0] ftag, input logic [15:0] ch,
                           input logic [31:0] rt, input logic [31:0] br,
                           input logic [15:0] bits, input logic [31:0] dlen);
    begin_wave();
    put_fmt(ftag, ch, rt, br, bits, 16);
    put_data(dlen, 8);
  endtask

  task automatic cut_to(input int n);
    file_bytes = file_bytes[0:n-1];
  endtask

  // ---------------------------------------------------------------- directed tests

  task automatic test_reset_defaults();
    // file size resets to zero, so the walk stops at the first header
    wave_file(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd8);
    send_file();
  endtask

  task automatic test_good_files();
    wave_file(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd8);
    load_regs(file_bytes.size(), RST_MAX_CHANNELS, RST_REQUIRED_RATE, RST_MAX_CLIP_SEC);
    send_file();
    wave_file(16'd1, 16'd1, 32'd44100, 32'd44100, 16'd8, 32'd8);
    send_file();
    wave_file(16'd1, 16'd2, 32'd44100, 32'd1, 16'd16, 32'd8);
    send_file();
  endtask

  task automatic test_header_tags();
    load_regs(32'd100, RST_MAX_CHANNELS, RST_REQUIRED_RATE, RST_MAX_CLIP_SEC);
    file_bytes.delete();
    put_text("R");
    send_file();
    begin_wave();
    cut_to(11);
    send_file();
    wave_file(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd8);
    file_bytes[2] = 8'h00;
    send_file();
    wave_file(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd8);
    file_bytes[10] = 8'hFF;
    send_file();
  endtask

  task automatic test_chunk_size();
    wave_file(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd1000);
    load_regs(file_bytes.size(), RST_MAX_CHANNELS, RST_REQUIRED_RATE, RST_MAX_CLIP_SEC);
    send_file();
    // largest chunk that fits pushes the next header past 32 bits
    begin_wave();
    put_fmt(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 16);
    put_text("LIST");
    put_le(32'hFFFF_FFD7, 4);
    put_data(32'd100, 4);
    load_regs(32'hFFFF_FFFF, RST_MAX_CHANNELS, RST_REQUIRED_RATE, RST_MAX_CLIP_SEC);
    send_file();
  endtask

  task automatic test_format_checks();
    load_regs(32'd52, RST_MAX_CHANNELS, RST_REQUIRED_RATE, RST_MAX_CLIP_SEC);
    wave_file(16'd3, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd8);
    send_file();
    wave_file(16'h0101, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd8);
    send_file();
    wave_file(16'd1, 16'd0, 32'd44100, 32'd176400, 16'd16, 32'd8);
    send_file();
    wave_file(16'd1, 16'd3, 32'd44100, 32'd176400, 16'd16, 32'd8);
    send_file();
    wave_file(16'd1, 16'd2, 32'd48000, 32'd192000, 16'd16, 32'd8);
    send_file();
    wave_file(16'd1, 16'd2, 32'd44100, 32'd264600, 16'd24, 32'd8);
    send_file();
    wave_file(16'd1, 16'd2, 32'd44100, 32'd0, 16'd16, 32'd8);
    send_file();
    // twelve payload bytes at one byte per second overrun ten seconds
    wave_file(16'd1, 16'd2, 32'd44100, 32'd1, 16'd16, 32'd12);
    send_file();
    wave_file(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd0);
    send_file();
    begin_wave();
    put_fmt(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 16);
    put_text("LIST");
    put_le(32'd8, 4);
    put_rand(8);
    send_file();
  endtask

  task automatic test_fmt_edges();
    // pcm flag stays set across a second non-pcm fmt chunk, fields follow the second
    begin_wave();
    put_fmt(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 16);
    put_fmt(16'd3, 16'd1, 32'd44100, 32'd88200, 16'd8, 16);
    put_data(32'd8, 8);
    load_regs(file_bytes.size(), RST_MAX_CHANNELS, RST_REQUIRED_RATE, RST_MAX_CLIP_SEC);
    send_file();
    // fmt fields beyond the file size read as zero
    wave_file(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd8);
    load_regs(32'd32, RST_MAX_CHANNELS, RST_REQUIRED_RATE, RST_MAX_CLIP_SEC);
    send_file();
    load_regs(32'd52, RST_MAX_CHANNELS, RST_REQUIRED_RATE, RST_MAX_CLIP_SEC);
    // stream stops on the format tag low byte
    wave_file(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd8);
    cut_to(21);
    send_file();
    // short fmt chunk, the data header overlaps the rate and byte rate fields
    begin_wave();
    put_fmt(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 4);
    put_data(32'd8, 8);
    send_file();
  endtask

  task automatic test_register_extremes();
    load_regs(32'd52, 16'd1, RST_REQUIRED_RATE, RST_MAX_CLIP_SEC);
    wave_file(16'd1, 16'd1, 32'd44100, 32'd44100, 16'd16, 32'd8);
    send_file();
    wave_file(16'd1, 16'd2, 32'd44100, 32'd44100, 16'd16, 32'd8);
    send_file();
    load_regs(32'd52, 16'hFFFF, 32'd0, RST_MAX_CLIP_SEC);
    wave_file(16'd1, 16'hFFFF, 32'd0, 32'd44100, 16'd8, 32'd8);
    send_file();
    load_regs(32'd52, RST_MAX_CHANNELS, 32'hFFFF_FFFF, 16'hFFFF);
    wave_file(16'd1, 16'd2, 32'hFFFF_FFFF, 32'd1, 16'd16, 32'd12);
    send_file();
    load_regs(32'd52, RST_MAX_CHANNELS, RST_REQUIRED_RATE, 16'd0);
    wave_file(16'd1, 16'd2, 32'd44100, 32'hFFFF_FFFF, 16'd16, 32'd8);
    send_file();
    load_regs(32'd0, RST_MAX_CHANNELS, RST_REQUIRED_RATE, RST_MAX_CLIP_SEC);
    wave_file(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd16, 32'd8);
    send_file();
  endtask

  // ---------------------------------------------------------------- random files

  task automatic pick_random_regs();
    logic [WORD_W-1:0] fs;
    logic [HALF_W-1:0] mc;
    logic [WORD_W-1:0] rt;
    logic [HALF_W-1:0] clip;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) fs = $urandom_range(44, 90);
    else if (r < 60) fs = $urandom_range(20, 43);
    else if (r < 80) fs = $urandom;
    else if (r < 90) fs = 32'hFFFF_FFFF;
    else fs = 32'd0;
    r = $urandom_range(0, 99);
    if (r < 70) mc = 16'($urandom_range(1, 8));
    else if (r < 80) mc = 16'd1;
    else if (r < 90) mc = 16'hFFFF;
    else mc = 16'($urandom_range(1, 65535));
    r = $urandom_range(0, 99);
    if (r < 60) rt = 32'd44100;
    else if (r < 80) rt = $urandom_range(8000, 96000);
    else if (r < 90) rt = 32'd0;
    else rt = $urandom;
    r = $urandom_range(0, 99);
    if (r < 60) clip = 16'd10;
    else if (r < 80) clip = 16'($urandom_range(0, 65535));
    else if (r < 90) clip = 16'd0;
    else clip = 16'hFFFF;
    load_regs(fs, mc, rt, clip);
  endtask

  // mostly well-formed files sized to the current register, the rest mangled
  task automatic build_random_file();
    logic [15:0] ftag;
    logic [15:0] ch;
    logic [31:0] rt;
    logic [31:0] br;
    logic [15:0] bits;
    logic [31:0] dlen;
    int flen;
    int junk;
    int hdr;
    int cap;
    int lim;
    int r;
    ftag = ($urandom_range(0, 9) != 0) ? 16'd1 : 16'($urandom);
    lim = (maxch_r > 16'd8) ? 8 : int'(maxch_r);
    r = $urandom_range(0, 99);
    if (r < 80) ch = 16'($urandom_range(1, lim));
    else if (r < 87) ch = 16'd0;
    else if (r < 94) ch = maxch_r + 16'd1;
    else ch = 16'($urandom);
    rt = ($urandom_range(0, 99) < 85) ? rate_r : $urandom;
    r = $urandom_range(0, 99);
    if (r < 85) bits = $urandom_range(0, 1) ? BITS_16 : BITS_8;
    else bits = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 80) br = $urandom;
    else if (r < 90) br = $urandom_range(0, 20);
    else br = 32'd0;
    r = $urandom_range(0, 99);
    if (r < 80) flen = 16;
    else if (r < 90) flen = 18;
    else flen = $urandom_range(0, 15);
    junk = ($urandom_range(0, 99) < 60) ? -1 : $urandom_range(0, 6);
    hdr = 12 + ((junk >= 0) ? 8 + junk : 0) + 8 + flen + 8;
    if (u64_t'(fs_r) >= u64_t'(hdr)) dlen = fs_r - 32'(hdr);
    else dlen = $urandom_range(0, 4);
    cap = $urandom_range(0, 8);

    begin_wave();
    if (junk >= 0) begin
      // an early junk chunk, at times an fmt chunk whose fields the real one must clear
      put_text(($urandom_range(0, 4) == 0) ? "fmt " : "LIST");
      put_le(junk, 4);
      put_rand(junk);
    end
    put_fmt(ftag, ch, rt, br, bits, flen);
    put_data(dlen, (dlen < 32'(cap)) ? int'(dlen) : cap);

    r = $urandom_range(0, 99);
    if (r >= 70 && r < 80 || r >= 95) begin
      repeat ($urandom_range(1, 3))
        file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
    end
    if (r >= 80 && r < 90 || r >= 95) cut_to($urandom_range(1, file_bytes.size()));
    if (r >= 90 && r < 95) begin
      file_bytes.delete();
      put_rand($urandom_range(1, 30));
    end
  endtask

  task automatic test_random_files();
    int files;
    int bytes;
    files = 0;
    bytes = 0;
    while (bytes < 300 || files < 4) begin
      pick_random_regs();
      repeat ($urandom_range(3, 8)) begin
        if ($urandom_range(0, 9) == 0) drain_results();
        build_random_file();
        bytes += file_bytes.size();
        files++;
        send_file();
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FILE_SIZE;
    cfg_data = '0;
    steady = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_good_files();
    test_header_tags();
    test_chunk_size();
    test_format_checks();
    test_fmt_edges();
    test_register_extremes();
    test_random_files();

    drain_results();
    repeat (8) @(posedge clk);
    $display("checked %0d file verdicts over %0d byte transfers", files_checked, bytes_sent);
    $display("verdicts ok/wave/chunk/pcm/chan/rate/bits/len: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("** wav_header_validator_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d verdicts never arrived", mismatches, verdict_q.size());
      $display("** wav_header_validator_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/wvh_pkg.sv
hw/rtl/wav_header_validator_top.sv
tb/sv/wav_header_validator_top_test.sv
